// ----- rtl/mstw_pkg.sv -----
`timescale 1ns / 1ps

package mstw_pkg;

  // field widths
  localparam int SLOT_W    = 4;
  localparam int REG_W     = 31;
  localparam int TIME_W    = 32;
  localparam int EV_SLOT_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_NUM_SLOTS = 16;

  // config registers
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_THRESHOLD = 2'd1;
  localparam logic [REG_W-1:0]     MIN_REG_MS          = 31'd1000;
  localparam logic [REG_W-1:0]     DEF_TIMEOUT_RST     = 31'd30000;
  localparam logic [REG_W-1:0]     STALL_THR_RST       = 31'd10000;

  // request codes
  localparam logic [1:0] OP_WATCH    = 2'd0;
  localparam logic [1:0] OP_UNWATCH  = 2'd1;
  localparam logic [1:0] OP_PROGRESS = 2'd2;
  localparam logic [1:0] OP_CHECK    = 2'd3;

  // event codes
  localparam logic EV_STALL   = 1'b0;
  localparam logic EV_TIMEOUT = 1'b1;

  // front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [REG_W-1:0]  tmo;   // already resolved against the default
    logic [TIME_W-1:0] now;
  } q_entry_t;

endpackage

// ----- rtl/mstw_if.sv -----
`timescale 1ns / 1ps

interface mstw_req_if import mstw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [SLOT_W-1:0] slot;
  logic [REG_W-1:0]  timeout_ms;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, req_type, slot, timeout_ms, now_ms, input ready);
  modport sink   (input valid, req_type, slot, timeout_ms, now_ms, output ready);
endinterface

interface mstw_evt_if import mstw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 event_kind;
  logic [EV_SLOT_W-1:0] event_slot;
  logic [TIME_W-1:0]    duration_ms;
  logic                 last;

  modport source (output valid, event_kind, event_slot, duration_ms, last, input ready);
  modport sink   (input valid, event_kind, event_slot, duration_ms, last, output ready);
endinterface

// ----- rtl/mstw_front.sv -----
`timescale 1ns / 1ps

module mstw_front import mstw_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_data,
  mstw_req_if.sink             req,
  output logic                 q_valid,
  input  logic                 q_ready,
  output q_entry_t             q_entry,
  output logic [REG_W-1:0]     stall_threshold
);

  logic [REG_W-1:0]  default_timeout;
  logic [REG_W-1:0]  cfg_val;
  q_entry_t          q_mem [QDEPTH];
  q_entry_t          in_entry;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              in_fire;
  logic              keep;
  logic              push;
  logic              pop;

  // values below the floor are raised to it
  assign cfg_val = (cfg_data < MIN_REG_MS) ? MIN_REG_MS : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_timeout <= DEF_TIMEOUT_RST;
      stall_threshold <= STALL_THR_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_DEFAULT_TIMEOUT) begin
        default_timeout <= cfg_val;
      end else if (cfg_idx == CFG_STALL_THRESHOLD) begin
        stall_threshold <= cfg_val;
      end
    end
  end

  // classify: out-of-range slots are dropped here, zero timeout resolved here
  assign req.ready = (count != QCNT_W'(QDEPTH));
  assign in_fire   = req.valid && req.ready;
  assign keep      = (req.req_type == OP_CHECK) || (int'(req.slot) < NUM_SLOTS);
  assign push      = in_fire && keep;
  assign pop       = q_valid && q_ready;
  assign q_valid   = (count != '0);
  assign q_entry   = q_mem[rd_ptr];

  always_comb begin
    in_entry.op   = req.req_type;
    in_entry.slot = req.slot;
    in_entry.tmo  = (req.timeout_ms == '0) ? default_timeout : req.timeout_ms;
    in_entry.now  = req.now_ms;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/mstw_back.sv -----
`timescale 1ns / 1ps

module mstw_back import mstw_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  q_entry_t         q_entry,
  input  logic [REG_W-1:0] stall_threshold,
  mstw_evt_if.source       evt
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_P1    = 2'd1;  // stall pass, marks expiries
  localparam logic [1:0] ST_P2    = 2'd2;  // timeout pass
  localparam logic [1:0] ST_FLUSH = 2'd3;  // last held event goes out

  logic [1:0]           state;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     idx_next;
  logic [IDX_W-1:0]     wr_slot;
  logic [TIME_W-1:0]    cur_now;

  logic [NUM_SLOTS-1:0] valid_bits;
  logic [NUM_SLOTS-1:0] stall_bits;
  logic [NUM_SLOTS-1:0] mark;

  logic [TIME_W-1:0]    start_mem [NUM_SLOTS];
  logic [TIME_W-1:0]    prog_mem  [NUM_SLOTS];
  logic [REG_W-1:0]     tmo_mem   [NUM_SLOTS];
  logic [TIME_W-1:0]    rd_start;
  logic [TIME_W-1:0]    rd_prog;
  logic [REG_W-1:0]     rd_tmo;

  logic                 pend_valid;
  logic                 pend_kind;
  logic [EV_SLOT_W-1:0] pend_slot;
  logic [TIME_W-1:0]    pend_dur;

  logic                 out_valid;
  logic                 out_kind;
  logic [EV_SLOT_W-1:0] out_slot;
  logic [TIME_W-1:0]    out_dur;
  logic                 out_last;

  logic                 q_fire;
  logic                 wr_watch;
  logic                 wr_prog;
  logic [TIME_W-1:0]    elapsed;
  logic [TIME_W-1:0]    since;
  logic                 hit_tmo;
  logic                 hit_stl;
  logic                 scanning;
  logic                 ev_gen;
  logic                 ev_kind;
  logic [TIME_W-1:0]    ev_dur;
  logic                 out_free;
  logic                 step_ok;
  logic                 ev_take;
  logic                 push_out;
  logic                 scan_end;

  assign q_ready  = (state == ST_IDLE);
  assign q_fire   = q_valid && q_ready;
  assign wr_slot  = IDX_W'(q_entry.slot);
  assign wr_watch = q_fire && (q_entry.op == OP_WATCH);
  assign wr_prog  = q_fire && (q_entry.op == OP_PROGRESS) && valid_bits[wr_slot];

  // slot evaluation on the registered read of the current index
  assign elapsed  = cur_now - rd_start;
  assign since    = cur_now - rd_prog;
  assign hit_tmo  = valid_bits[idx] && (elapsed >= {1'b0, rd_tmo});
  assign hit_stl  = valid_bits[idx] && !hit_tmo && !stall_bits[idx] &&
                    (since >= {1'b0, stall_threshold});

  assign scanning = (state == ST_P1) || (state == ST_P2);
  assign ev_gen   = ((state == ST_P1) && hit_stl) || ((state == ST_P2) && mark[idx]);
  assign ev_kind  = (state == ST_P2) ? EV_TIMEOUT : EV_STALL;
  assign ev_dur   = (state == ST_P2) ? elapsed : since;

  // one event is held back so that the final one can carry last
  assign out_free = !out_valid || evt.ready;
  assign step_ok  = !ev_gen || !pend_valid || out_free;
  assign ev_take  = scanning && ev_gen && step_ok;
  assign push_out = (ev_take && pend_valid) ||
                    ((state == ST_FLUSH) && pend_valid && out_free);
  assign scan_end = (idx == LAST_IDX);

  always_comb begin
    idx_next = idx;
    if (!scanning) begin
      idx_next = '0;
    end else if (step_ok) begin
      idx_next = scan_end ? '0 : idx + 1'b1;
    end
  end

  // slot store: one write address, one registered read at the next index
  always_ff @(posedge clk) begin
    if (wr_watch) begin
      start_mem[wr_slot] <= q_entry.now;
      tmo_mem[wr_slot]   <= q_entry.tmo;
    end
    if (wr_watch || wr_prog) begin
      prog_mem[wr_slot] <= q_entry.now;
    end
    rd_start <= start_mem[idx_next];
    rd_prog  <= prog_mem[idx_next];
    rd_tmo   <= tmo_mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      valid_bits <= '0;
      mark       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      idx <= idx_next;
      if (push_out) begin
        out_valid <= 1'b1;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_fire) begin
            case (q_entry.op)
              OP_WATCH:   valid_bits[wr_slot] <= 1'b1;
              OP_UNWATCH: valid_bits[wr_slot] <= 1'b0;
              OP_CHECK:   state <= ST_P1;
              default:    ;
            endcase
          end
        end
        ST_P1: begin
          if (step_ok) begin
            if (hit_tmo) begin
              mark[idx] <= 1'b1;
            end
            if (ev_take) begin
              pend_valid <= 1'b1;
            end
            if (scan_end) begin
              state <= ST_P2;
            end
          end
        end
        ST_P2: begin
          if (step_ok) begin
            if (mark[idx]) begin
              mark[idx]       <= 1'b0;
              valid_bits[idx] <= 1'b0;
            end
            if (ev_take) begin
              pend_valid <= 1'b1;
            end
            if (scan_end) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_P1) && step_ok && hit_stl) begin
      stall_bits[idx] <= 1'b1;
    end
    if (wr_watch || wr_prog) begin
      stall_bits[wr_slot] <= 1'b0;
    end
    if (q_fire && (q_entry.op == OP_CHECK)) begin
      cur_now <= q_entry.now;
    end
    if (ev_take) begin
      pend_kind <= ev_kind;
      pend_slot <= EV_SLOT_W'(idx);
      pend_dur  <= ev_dur;
    end
    if (push_out) begin
      out_kind <= pend_kind;
      out_slot <= pend_slot;
      out_dur  <= pend_dur;
      out_last <= (state == ST_FLUSH);
    end
  end

  assign evt.valid       = out_valid;
  assign evt.event_kind  = out_kind;
  assign evt.event_slot  = out_slot;
  assign evt.duration_ms = out_dur;
  assign evt.last        = out_last;

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held event left over outside a check");

  a_idle_no_mark: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (mark == '0))
    else $error("expiry mark survived the timeout pass");

  a_mark_valid: assert property (@(posedge clk) disable iff (rst)
    (mark & ~valid_bits) == '0)
    else $error("expiry mark on a free slot");

  a_p2_timeout: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_P2) && ev_take) |=> (pend_kind == EV_TIMEOUT))
    else $error("timeout pass produced a stall event");
`endif

endmodule

// ----- rtl/multi_slot_task_watchdog.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// req       in   valid/ready    req_type, slot, timeout_ms, now_ms
// evt       out  valid/ready    event_kind, event_slot, duration_ms, last
// cfg       in   cfg_we only    cfg_idx, cfg_data
//
// Watch, unwatch and progress requests are handled in the slot engine's idle state.
// A check holds the slot engine through the accepting state, a stall pass
// over the slots, a timeout pass over the slots and a flush that releases
// the last event; the slot store has a single read port, so each pass
// visits one slot at a time.
// Events stall the scan only when the output register and the held event
// are both occupied; a two-entry queue keeps the request side open meanwhile.
// rst (synchronous) clears the valid bits and the queue and returns the
// config registers to their defaults; the slot store itself is not cleared.

module multi_slot_task_watchdog import mstw_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_data,
  mstw_req_if.sink             req,
  mstw_evt_if.source           evt
);

  // front -> back queue head
  logic             q_valid;
  logic             q_ready;
  q_entry_t         q_entry;
  // stall threshold lives with the config registers in the front
  logic [REG_W-1:0] stall_threshold;

  // Front: config registers, request classification (out-of-range slots
  // dropped, zero timeout replaced by the default), two-entry queue.
  mstw_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .req             (req),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_entry         (q_entry),
    .stall_threshold (stall_threshold)
  );

  // Back: slot store, check sequencer and event output register.
  mstw_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_entry         (q_entry),
    .stall_threshold (stall_threshold),
    .evt             (evt)
  );

endmodule
